// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL module of the cache set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition in one cycle brings about another in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/cslru_pkg.sv =====
// Types and fixed constants of the cache set LRU lookup block.
package cslru_pkg;

   localparam int WAYS        = 4;
   localparam int WAY_BITS    = 2;
   localparam int TAG_BITS    = 20;
   localparam int OFFSET_BITS = 4;
   localparam int DATA_BITS   = 8;
   localparam int COUNT_BITS  = 3;

   // Request kinds
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_READ   = 2'd1,
      OP_WRITE  = 2'd2,
      OP_FILL   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 req_type;
      logic [TAG_BITS-1:0]    tag;
      logic [WAY_BITS-1:0]    way;
      logic [OFFSET_BITS-1:0] offset;
      logic [DATA_BITS-1:0]   write_value;
   } request_type;

   typedef struct packed {
      logic                  hit;
      logic [WAY_BITS-1:0]   hit_way;
      logic [DATA_BITS-1:0]  read_data;
      logic [WAY_BITS-1:0]   victim_way;
      logic [COUNT_BITS-1:0] filled_ways;
   } result_type;

endpackage

// ===== hdl/cache_set_lru_lookup.sv =====
// One four-way cache set: tag lookup, byte read, byte write and byte fill with
// age-counter LRU. The block takes one request per clock while it does not
// stall and returns one result per request. The accepting edge registers the
// request and reads the byte store (a RAM with registered read data). The
// edge on which the request stage advances updates valid bits, tags, ages and
// the filled count and registers the result.
// The byte store is written at acceptance; it has no reset and no clearing
// pass, so a byte must be written before it is read. Each result reports the
// victim way and filled count after the request has updated the set. A stall
// on a waiting result holds the request stage, and while that stage is full
// the request side stalls.
`include "assert_macros.svh"

module cache_set_lru_lookup #(
   parameter int BLOCK_BYTES = 16,
   parameter int AGE_BITS    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cslru_pkg::request_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cslru_pkg::result_type   rsp_data
);

   localparam int DEPTH     = cslru_pkg::WAYS * BLOCK_BYTES;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int OFF_BITS  = $clog2(BLOCK_BYTES);

   // Handshake control
   logic rsp_open;
   logic s1_fire;
   logic req_accept;

   // Request stage
   logic                   s1_valid_ff, s1_valid_in;
   cslru_pkg::request_type s1_req_ff;

   // Result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   cslru_pkg::result_type rsp_data_ff, rsp_data_in;

   // Set state
   logic [cslru_pkg::WAYS-1:0]       valid_ff, valid_in;
   logic [cslru_pkg::TAG_BITS-1:0]   tag_ff [cslru_pkg::WAYS];
   logic [cslru_pkg::TAG_BITS-1:0]   tag_in [cslru_pkg::WAYS];
   logic [AGE_BITS-1:0]              age_ff [cslru_pkg::WAYS];
   logic [AGE_BITS-1:0]              age_in [cslru_pkg::WAYS];
   logic [cslru_pkg::COUNT_BITS-1:0] filled_ff, filled_in;

   // Byte store access
   logic [OFF_BITS-1:0]             req_off_idx;
   logic                            req_off_ok;
   logic [ADDR_BITS-1:0]            ram_addr;
   logic                            ram_we;
   logic                            ram_re;
   logic [cslru_pkg::DATA_BITS-1:0] ram_rdata;

   // Lookup and victim search
   logic                             s1_off_ok;
   logic [cslru_pkg::WAYS-1:0]       in_range;
   logic [cslru_pkg::WAYS-1:0]       match;
   logic                             any_match;
   logic [cslru_pkg::WAY_BITS-1:0]   match_way;
   logic [cslru_pkg::WAY_BITS-1:0]   best_way;
   logic [AGE_BITS-1:0]              best_age;

   // Advance the request stage whenever the result register can take its item
   assign rsp_open   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && rsp_open;
   assign req_stall  = s1_valid_ff && !rsp_open;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_valid;
   assign rsp_valid_in = s1_valid_ff;

   // Write or read the byte store as the request is accepted
   assign req_off_idx = OFF_BITS'(req_data.offset);
   assign req_off_ok  = int'(req_data.offset) < BLOCK_BYTES;
   assign ram_addr    = ADDR_BITS'(ADDR_BITS'(req_data.way) * ADDR_BITS'(BLOCK_BYTES)
                        + ADDR_BITS'(req_off_idx));
   assign ram_we      = req_accept && req_off_ok
                        && (req_data.req_type == cslru_pkg::OP_WRITE
                            || req_data.req_type == cslru_pkg::OP_FILL);
   assign ram_re      = req_accept && req_data.req_type == cslru_pkg::OP_READ;

   cslru_ram #(
      .WIDTH (cslru_pkg::DATA_BITS),
      .DEPTH (DEPTH)
   ) u_bytes (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_data.write_value),
      .rdata (ram_rdata)
   );

   // Compare tags against filled, valid ways; first match by index wins
   always_comb begin
      s1_off_ok = int'(s1_req_ff.offset) < BLOCK_BYTES;
      for (int i = 0; i < cslru_pkg::WAYS; i++) begin
         in_range[i] = cslru_pkg::COUNT_BITS'(i) < filled_ff;
         match[i]    = valid_ff[i] && in_range[i] && (tag_ff[i] == s1_req_ff.tag);
      end
      any_match = |match;
      match_way = '0;
      for (int i = cslru_pkg::WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_way = cslru_pkg::WAY_BITS'(i);
         end
      end
   end

   // Update valid bits, tags, ages and filled count for the request
   always_comb begin
      valid_in    = valid_ff;
      tag_in      = tag_ff;
      age_in      = age_ff;
      filled_in   = filled_ff;
      rsp_data_in = '0;
      case (s1_req_ff.req_type)
         cslru_pkg::OP_LOOKUP: begin
            if (any_match) begin
               for (int i = 0; i < cslru_pkg::WAYS; i++) begin
                  if (in_range[i] && age_ff[i] != '1) begin
                     age_in[i] = age_ff[i] + 1'b1;
                  end
               end
               age_in[match_way]   = '0;
               rsp_data_in.hit     = 1'b1;
               rsp_data_in.hit_way = match_way;
            end
         end
         cslru_pkg::OP_READ: begin
            age_in[s1_req_ff.way] = '0;
            if (s1_off_ok) begin
               rsp_data_in.read_data = ram_rdata;
            end
         end
         cslru_pkg::OP_WRITE: begin
            age_in[s1_req_ff.way] = '0;
         end
         cslru_pkg::OP_FILL: begin
            age_in[s1_req_ff.way]   = '0;
            tag_in[s1_req_ff.way]   = s1_req_ff.tag;
            valid_in[s1_req_ff.way] = 1'b1;
            if (cslru_pkg::COUNT_BITS'(s1_req_ff.way) + 1'b1 > filled_ff) begin
               filled_in = cslru_pkg::COUNT_BITS'(s1_req_ff.way) + 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Pick the oldest filled way after the update, lower index on ties
      best_way = '0;
      best_age = age_in[0];
      for (int i = 1; i < cslru_pkg::WAYS; i++) begin
         if (cslru_pkg::COUNT_BITS'(i) < filled_in && age_in[i] > best_age) begin
            best_age = age_in[i];
            best_way = cslru_pkg::WAY_BITS'(i);
         end
      end
      rsp_data_in.victim_way  = best_way;
      rsp_data_in.filled_ways = filled_in;
   end

   // Hold control state and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         filled_ff    <= '0;
         for (int i = 0; i < cslru_pkg::WAYS; i++) begin
            tag_ff[i] <= '0;
            age_ff[i] <= '0;
         end
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (rsp_open) begin
            rsp_valid_ff <= rsp_valid_in;
         end
         if (s1_fire) begin
            valid_ff  <= valid_in;
            tag_ff    <= tag_in;
            age_ff    <= age_in;
            filled_ff <= filled_in;
         end
      end
   end

   // Capture request and result payloads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_ALWAYS(a_filled_range, filled_ff <= cslru_pkg::COUNT_BITS'(cslru_pkg::WAYS), "filled count beyond way count")
   `ASSERT_ALWAYS(a_valid_below_filled, (valid_ff & ~in_range) == '0, "valid way at or above filled count")
   `ASSERT_NEXT(a_filled_grows, s1_fire, filled_ff >= $past(filled_ff), "filled count decreased")
   `ASSERT_NEXT(a_hit_way_young, s1_fire && rsp_data_in.hit, age_ff[rsp_data_ff.hit_way] == '0, "hit way age not cleared")

endmodule

// ===== hdl/cslru_ram.sv =====
// Generic single-port RAM with registered read data.
module cslru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read at one address; read data held until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/cache_set_lru_lookup_tb.sv =====
// Self-checking testbench for the four-way cache set with age-counter LRU.
module cache_set_lru_lookup_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AGE_W        = 16;
   localparam int BLOCK_LEN    = 16;
   localparam int HOLD_CYCLES  = 80;
   localparam int AGE_LOOKUPS  = 40;
   localparam int RUN_LIMIT    = 1_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam int REQ_BITS     = $bits(cslru_pkg::request_type);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   cslru_pkg::request_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   cslru_pkg::result_type  rsp_data;

   // Shadow copy of the cache set
   logic                              shadow_valid [cslru_pkg::WAYS];
   logic [cslru_pkg::TAG_BITS-1:0]    shadow_tag   [cslru_pkg::WAYS];
   logic [AGE_W-1:0]                  shadow_age   [cslru_pkg::WAYS];
   logic [cslru_pkg::DATA_BITS-1:0]   shadow_bytes [cslru_pkg::WAYS][BLOCK_LEN];
   logic                              byte_written [cslru_pkg::WAYS][BLOCK_LEN];
   logic [cslru_pkg::COUNT_BITS-1:0]  shadow_count;

   cslru_pkg::result_type awaited_results[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   cache_set_lru_lookup uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Drive the result stall: a long hold-off when asked, otherwise random
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Apply one request to the shadow set and return the result it yields
   function automatic cslru_pkg::result_type access_set(cslru_pkg::request_type r);
      cslru_pkg::result_type res;
      int                    w;
      int                    best;
      logic [AGE_W-1:0]      best_age;
      res = '0;
      w = r.way;
      case (r.req_type)
         cslru_pkg::OP_LOOKUP: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (!res.hit && shadow_valid[i] && shadow_tag[i] == r.tag) begin
                  res.hit     = 1'b1;
                  res.hit_way = cslru_pkg::WAY_BITS'(i);
               end
            end
            // age every filled way, saturating, then refresh the hit way
            if (res.hit) begin
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_age[i] != '1) shadow_age[i]++;
               end
               shadow_age[res.hit_way] = '0;
            end
         end
         cslru_pkg::OP_READ: begin
            shadow_age[w] = '0;
            res.read_data = shadow_bytes[w][r.offset];
         end
         cslru_pkg::OP_WRITE: begin
            shadow_age[w] = '0;
            shadow_bytes[w][r.offset] = r.write_value;
            byte_written[w][r.offset] = 1'b1;
         end
         cslru_pkg::OP_FILL: begin
            shadow_age[w] = '0;
            shadow_bytes[w][r.offset] = r.write_value;
            byte_written[w][r.offset] = 1'b1;
            shadow_tag[w]   = r.tag;
            shadow_valid[w] = 1'b1;
            if (w + 1 > shadow_count) shadow_count = cslru_pkg::COUNT_BITS'(w + 1);
         end
         default: ;
      endcase
      // pick the oldest filled way, lowest index on ties
      best = 0;
      best_age = shadow_age[0];
      for (int i = 1; i < shadow_count; i++) begin
         if (shadow_age[i] > best_age) begin
            best_age = shadow_age[i];
            best = i;
         end
      end
      res.victim_way  = cslru_pkg::WAY_BITS'(best);
      res.filled_ways = shadow_count;
      return res;
   endfunction

   // Offer one request after random idle cycles and record its expected result
   task automatic offer_request(input cslru_pkg::request_type r);
      logic [REQ_BITS-1:0] junk;
      while ($urandom_range(99) < idle_pct) begin
         junk = REQ_BITS'({$urandom(), $urandom()});
         req_valid <= 1'b0;
         req_data  <= junk;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_results.push_back(access_set(r));
   endtask

   task automatic send(input cslru_pkg::op_type op,
                       input logic [cslru_pkg::TAG_BITS-1:0] tag,
                       input int way, input int offset, input int value);
      cslru_pkg::request_type r;
      r.req_type    = op;
      r.tag         = tag;
      r.way         = cslru_pkg::WAY_BITS'(way);
      r.offset      = cslru_pkg::OFFSET_BITS'(offset);
      r.write_value = cslru_pkg::DATA_BITS'(value);
      offer_request(r);
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      cslru_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result %p at cycle %0d", rsp_data, cycle_count);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.hit_way !== want.hit_way ||
                rsp_data.read_data !== want.read_data ||
                rsp_data.victim_way !== want.victim_way ||
                rsp_data.filled_ways !== want.filled_ways) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch at cycle %0d: expected %p, got %p",
                           cycle_count, want, rsp_data);
            end
         end
      end
   end

   // Walk the set through empty, partly filled and full states
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send(cslru_pkg::OP_LOOKUP, 20'h00000, 0, 0, 0);      // empty set: reset tag must not hit
      send(cslru_pkg::OP_WRITE,  20'h00000, 3, 15, 8'hFF); // way above the filled count
      send(cslru_pkg::OP_READ,   20'h00000, 3, 15, 0);
      send(cslru_pkg::OP_FILL,   20'hFFFFF, 2, 0, 8'h00);  // ways 0 and 1 unfilled below count
      send(cslru_pkg::OP_LOOKUP, 20'hFFFFF, 0, 0, 0);
      send(cslru_pkg::OP_LOOKUP, 20'h00000, 0, 0, 0);      // unfilled ways below count miss
      send(cslru_pkg::OP_FILL,   20'h00000, 0, 15, 8'hA5);
      send(cslru_pkg::OP_LOOKUP, 20'h00000, 0, 0, 0);
      send(cslru_pkg::OP_FILL,   20'hFFFFF, 3, 7, 8'h5A);  // duplicate tag: first way wins
      send(cslru_pkg::OP_LOOKUP, 20'hFFFFF, 0, 0, 0);
      send(cslru_pkg::OP_FILL,   20'h12345, 1, 8, 8'h80);
      send(cslru_pkg::OP_WRITE,  20'h00000, 1, 0, 8'h01);
      send(cslru_pkg::OP_READ,   20'h00000, 1, 0, 0);
      send(cslru_pkg::OP_READ,   20'h00000, 2, 0, 0);
      send(cslru_pkg::OP_READ,   20'h00000, 0, 15, 0);
      send(cslru_pkg::OP_LOOKUP, 20'h12345, 0, 0, 0);
      send(cslru_pkg::OP_LOOKUP, 20'h00000, 0, 0, 0);
      send(cslru_pkg::OP_LOOKUP, 20'hFFFFF, 0, 0, 0);
      send(cslru_pkg::OP_LOOKUP, 20'h54321, 0, 0, 0);      // miss leaves ages alone
      send(cslru_pkg::OP_FILL,   20'h0F0F0, 0, 3, 8'h3C);  // refill below count
      send(cslru_pkg::OP_LOOKUP, 20'h00000, 0, 0, 0);
      send(cslru_pkg::OP_READ,   20'h00000, 3, 7, 0);
   endtask

   // Age the other ways with a run of hits on one way
   task automatic test_aging();
      idle_pct  = 0;
      stall_pct = 0;
      send(cslru_pkg::OP_FILL, 20'hABCDE, 0, 0, 8'h11);
      for (int n = 0; n < AGE_LOOKUPS; n++) send(cslru_pkg::OP_LOOKUP, 20'hABCDE, 0, 0, 0);
      send(cslru_pkg::OP_WRITE,  20'h00000, 1, 4, 8'h77);
      send(cslru_pkg::OP_LOOKUP, 20'hABCDE, 0, 0, 0);
   endtask

   function automatic cslru_pkg::request_type random_request();
      cslru_pkg::request_type r;
      int                     pick;
      int                     w;
      int                     o;
      logic                   found;
      r.req_type    = cslru_pkg::OP_LOOKUP;
      r.tag         = cslru_pkg::TAG_BITS'($urandom());
      r.way         = cslru_pkg::WAY_BITS'($urandom_range(3));
      r.offset      = cslru_pkg::OFFSET_BITS'($urandom_range(15));
      r.write_value = cslru_pkg::DATA_BITS'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 35) begin
         // mostly tags that are resident, so lookups hit
         if ($urandom_range(99) < 75) r.tag = shadow_tag[$urandom_range(3)];
      end else if (pick < 60) begin
         // read only bytes that hold data
         found = 1'b0;
         for (int a = 0; a < 64 && !found; a++) begin
            w = $urandom_range(3);
            o = $urandom_range(15);
            if (byte_written[w][o]) begin
               found = 1'b1;
               r.way = cslru_pkg::WAY_BITS'(w);
               r.offset = cslru_pkg::OFFSET_BITS'(o);
            end
         end
         r.req_type = found ? cslru_pkg::OP_READ : cslru_pkg::OP_WRITE;
      end else if (pick < 80) begin
         r.req_type = cslru_pkg::OP_WRITE;
      end else begin
         r.req_type = cslru_pkg::OP_FILL;
         if ($urandom_range(1)) r.tag = shadow_tag[r.way];
      end
      return r;
   endfunction

   // Random requests mixed with whole-block fills followed by lookups
   task automatic test_random(input int count, input int idle, input int stall);
      logic [cslru_pkg::TAG_BITS-1:0] t;
      int                             w;
      int                             n;
      idle_pct  = idle;
      stall_pct = stall;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 8) begin
            t = cslru_pkg::TAG_BITS'($urandom());
            w = $urandom_range(3);
            for (int o = 0; o < BLOCK_LEN; o++)
               send(cslru_pkg::OP_FILL, t, w, o, $urandom_range(255));
            send(cslru_pkg::OP_LOOKUP, t, 0, 0, 0);
            n += BLOCK_LEN + 1;
         end else begin
            offer_request(random_request());
            n++;
         end
      end
   endtask

   // Hold off the result side while requests keep coming
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_asked++;
      for (int n = 0; n < 40; n++) offer_request(random_request());
   endtask

   initial begin
      for (int i = 0; i < cslru_pkg::WAYS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_tag[i]   = '0;
         shadow_age[i]   = '0;
         for (int o = 0; o < BLOCK_LEN; o++) begin
            shadow_bytes[i][o] = '0;
            byte_written[i][o] = 1'b0;
         end
      end
      shadow_count = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_aging();
      test_random(135, 0, 0);
      test_random(135, 79, 0);
      test_random(135, 0, 79);
      test_random(135, 7, 7);
      test_backpressure();

      // drain outstanding results, then allow for stragglers
      req_valid <= 1'b0;
      stall_pct = 30;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cslru_pkg.sv
hdl/cslru_ram.sv
hdl/cache_set_lru_lookup.sv
tb/cache_set_lru_lookup_tb.sv
